@@ rtl/core/ptd_pkg.sv @@
`default_nettype none

package ptd_pkg;

  localparam int MAX_TASKS       = 8;
  localparam int LOWEST_PRIORITY = 7;
  localparam int IDX_W           = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W           = $clog2(MAX_TASKS + 1);
  localparam int PRI_W           = 3;

  localparam logic [7:0] WINDOW_RESET = 8'd120;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_NULL_TASK  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       task_id;
    logic [7:0]       period;
    logic [PRI_W-1:0] priority_req;
  } ptd_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       dispatch_valid;
    logic [7:0] dispatched_task;
    logic [7:0] tick_count;
    logic       last;
  } ptd_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/periodic_task_dispatcher.sv @@
// Periodic task dispatcher.
// Requests enter on req/req_valid and are taken at a clock edge where req_valid
// is high and req_stall is low. Results leave on rsp/rsp_valid and are taken
// when rsp_valid is high and rsp_stall is low. cfg_we/cfg_wdata write the
// schedule window length (reset value 120); write it only while idle.
// One request is handled at a time: req_stall stays high from acceptance
// until its final result (last = 1) has been loaded into the output register.
// Create and delete give one result, and so does an unused action; a tick
// that wraps the counter gives one idle result. Each is loaded from S_FIN.
// Any other tick checks each table entry for divisibility on one shared
// restoring-division step unit, one quotient bit per cycle; an entry with a
// zero period is never due. Then a priority walk visits the 8 levels from 0
// to 7 and gives one result per due task, lowest table index first within a
// level, followed by the idle result.
// A stalled receiver freezes the sequencer on its next result; nothing is lost.
// Synchronous reset empties the table, clears the counter, restores the window
// length and drops any pending result.
`default_nettype none

module periodic_task_dispatcher
  import ptd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire ptd_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output ptd_rsp_t      rsp,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] task_count;
  logic [7:0]       schedule_counter;
  logic [7:0]       window_length;
  logic [1:0]       fin_status;

  logic [7:0]       task_ids        [MAX_TASKS];
  logic [7:0]       task_periods    [MAX_TASKS];
  logic [PRI_W-1:0] task_priorities [MAX_TASKS];
  logic [MAX_TASKS-1:0] due;

  // shared division step unit
  logic [IDX_W-1:0] idx;
  logic [2:0]       step;
  logic [7:0]       rem;
  logic [7:0]       dvd;
  logic [PRI_W-1:0] prio;

  logic             accept;
  logic             rsp_free;
  logic [7:0]       counter_inc;
  logic [7:0]       cur_period;
  logic [8:0]       trial;
  logic             trial_ge;
  logic [7:0]       rem_next;
  logic             last_idx;
  logic [MAX_TASKS-1:0] level_mask;
  logic [IDX_W-1:0] pick;
  logic [MAX_TASKS-1:0] del_match;
  logic             del_hit;
  logic [IDX_W-1:0] del_pos;

  assign req_stall   = (state != S_IDLE);
  assign accept      = req_valid && !req_stall;
  assign rsp_free    = !rsp_valid || !rsp_stall;
  assign counter_inc = schedule_counter + 8'd1;
  assign cur_period  = task_periods[idx];
  assign trial       = {rem, dvd[7]};
  assign trial_ge    = trial >= {1'b0, cur_period};
  assign rem_next    = trial_ge ? 8'(trial - {1'b0, cur_period}) : trial[7:0];
  assign last_idx    = (CNT_W'(idx) + CNT_W'(1)) == task_count;

  always_comb begin
    level_mask = '0;
    del_match  = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      level_mask[i] = due[i] && (task_priorities[i] == prio);
      del_match[i]  = (CNT_W'(i) < task_count) && (task_ids[i] == req.task_id);
    end
  end

  always_comb begin
    pick    = '0;
    del_pos = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (level_mask[i]) begin
        pick = IDX_W'(i);
      end
      if (del_match[i]) begin
        del_pos = IDX_W'(i);
      end
    end
  end

  assign del_hit = |del_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // table storage, no reset
  always_ff @(posedge clk) begin
    if (accept && req.action == ACT_CREATE && req.task_id != 8'd0
        && task_count < CNT_W'(MAX_TASKS)) begin
      task_ids[IDX_W'(task_count)]        <= req.task_id;
      task_periods[IDX_W'(task_count)]    <= req.period;
      task_priorities[IDX_W'(task_count)] <= req.priority_req;
    end else if (accept && req.action == ACT_DELETE && req.task_id != 8'd0 && del_hit) begin
      // close the gap
      for (int j = 0; j < MAX_TASKS - 1; j++) begin
        if (IDX_W'(j) >= del_pos) begin
          task_ids[j]        <= task_ids[j+1];
          task_periods[j]    <= task_periods[j+1];
          task_priorities[j] <= task_priorities[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      task_count       <= '0;
      schedule_counter <= 8'd0;
      rsp_valid        <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fin_status <= ST_OK;
            state      <= S_FIN;
            unique case (req.action)
              ACT_CREATE: begin
                if (req.task_id == 8'd0) begin
                  fin_status <= ST_NULL_TASK;
                end else if (task_count >= CNT_W'(MAX_TASKS)) begin
                  fin_status <= ST_TABLE_FULL;
                end else begin
                  task_count <= task_count + CNT_W'(1);
                end
              end
              ACT_DELETE: begin
                if (req.task_id == 8'd0) begin
                  fin_status <= ST_NULL_TASK;
                end else if (del_hit) begin
                  task_count <= task_count - CNT_W'(1);
                end
              end
              ACT_TICK: begin
                due  <= '0;
                idx  <= '0;
                step <= 3'd0;
                rem  <= 8'd0;
                dvd  <= counter_inc;
                prio <= '0;
                if (counter_inc == window_length) begin
                  schedule_counter <= 8'd0;
                end else begin
                  schedule_counter <= counter_inc;
                  if (task_count != '0) begin
                    state <= S_MOD;
                  end else begin
                    state <= S_EMIT;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MOD: begin
          if (cur_period == 8'd0 || step == 3'd7) begin
            due[idx] <= (cur_period != 8'd0) && (rem_next == 8'd0);
            if (last_idx) begin
              state <= S_EMIT;
            end else begin
              idx  <= idx + IDX_W'(1);
              step <= 3'd0;
              rem  <= 8'd0;
              dvd  <= schedule_counter;
            end
          end else begin
            rem  <= rem_next;
            dvd  <= {dvd[6:0], 1'b0};
            step <= step + 3'd1;
          end
        end
        S_EMIT: begin
          if (|level_mask) begin
            if (rsp_free) begin
              rsp_valid           <= 1'b1;
              rsp.status          <= ST_OK;
              rsp.dispatch_valid  <= 1'b1;
              rsp.dispatched_task <= task_ids[pick];
              rsp.tick_count      <= schedule_counter;
              rsp.last            <= 1'b0;
              due[pick]           <= 1'b0;
            end
          end else if (prio == PRI_W'(LOWEST_PRIORITY)) begin
            state <= S_FIN;
          end else begin
            prio <= prio + PRI_W'(1);
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            rsp_valid           <= 1'b1;
            rsp.status          <= fin_status;
            rsp.dispatch_valid  <= 1'b0;
            rsp.dispatched_task <= 8'd0;
            rsp.tick_count      <= schedule_counter;
            rsp.last            <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= CNT_W'(MAX_TASKS))
    else $error("task table count exceeds capacity");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("request taken while busy");

  a_mod_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> (CNT_W'(idx) < task_count))
    else $error("divisibility check beyond table");

  a_nonlast_dispatch: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> rsp.dispatch_valid)
    else $error("non-final result without dispatch");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && rsp_free) |=> (state == S_IDLE && rsp_valid && rsp.last))
    else $error("final result not delivered");
`endif

endmodule

`default_nettype wire

@@ tb/sv/ptd_dispatch_checker.sv @@
`timescale 1ns / 100ps

module ptd_dispatch_checker
  import ptd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  ptd_req_t            req,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  ptd_rsp_t            rsp,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output int                  mismatches,
  output int                  results_due
);

  logic [7:0]       tbl_id     [MAX_TASKS];
  logic [7:0]       tbl_period [MAX_TASKS];
  logic [PRI_W-1:0] tbl_prio   [MAX_TASKS];
  int               tbl_used;
  logic [7:0]       sched_count;
  logic [7:0]       window_len;
  int               fail_total = 0;
  ptd_rsp_t         pending_results[$];

  function automatic void queue_result(logic [1:0] st, logic dv, logic [7:0] id, logic fin);
    ptd_rsp_t r;
    r.status          = st;
    r.dispatch_valid  = dv;
    r.dispatched_task = id;
    r.tick_count      = sched_count;
    r.last            = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_request(ptd_req_t r);
    int hit;
    case (r.action)
      ACT_CREATE: begin
        if (r.task_id == 8'd0) begin
          queue_result(ST_NULL_TASK, 1'b0, 8'd0, 1'b1);
        end else if (tbl_used >= MAX_TASKS) begin
          queue_result(ST_TABLE_FULL, 1'b0, 8'd0, 1'b1);
        end else begin
          tbl_id[tbl_used]     = r.task_id;
          tbl_period[tbl_used] = r.period;
          tbl_prio[tbl_used]   = r.priority_req;
          tbl_used++;
          queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (r.task_id == 8'd0) begin
          queue_result(ST_NULL_TASK, 1'b0, 8'd0, 1'b1);
        end else begin
          hit = -1;
          for (int i = 0; i < tbl_used; i++)
            if (hit < 0 && tbl_id[i] == r.task_id) hit = i;
          // remove only the first match and close the gap
          if (hit >= 0) begin
            for (int j = hit; j < tbl_used - 1; j++) begin
              tbl_id[j]     = tbl_id[j+1];
              tbl_period[j] = tbl_period[j+1];
              tbl_prio[j]   = tbl_prio[j+1];
            end
            tbl_used--;
          end
          queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      ACT_TICK: begin
        sched_count = sched_count + 8'd1;
        if (sched_count == window_len) begin
          sched_count = 8'd0;
        end else begin
          for (int p = 0; p <= LOWEST_PRIORITY; p++)
            for (int i = 0; i < tbl_used; i++)
              if (tbl_period[i] != 8'd0 && sched_count % tbl_period[i] == 8'd0 &&
                  tbl_prio[i] == p)
                queue_result(ST_OK, 1'b1, tbl_id[i], 1'b0);
        end
        queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
      end
      default: begin
        queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
      end
    endcase
  endfunction

  function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
    fail_total++;
    $error("%s: expected %0d, got %0d", name, want, got);
  endfunction

  function automatic void check_result(ptd_rsp_t got);
    ptd_rsp_t want;
    if (pending_results.size() == 0) begin
      fail_total++;
      $error("unexpected result: status %0d task %0d tick %0d",
             got.status, got.dispatched_task, got.tick_count);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_field("status", 8'(want.status), 8'(got.status));
    if (got.dispatch_valid !== want.dispatch_valid)
      report_field("dispatch_valid", 8'(want.dispatch_valid), 8'(got.dispatch_valid));
    if (got.dispatched_task !== want.dispatched_task)
      report_field("dispatched_task", want.dispatched_task, got.dispatched_task);
    if (got.tick_count !== want.tick_count)
      report_field("tick_count", want.tick_count, got.tick_count);
    if (got.last !== want.last)
      report_field("last", 8'(want.last), 8'(got.last));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tbl_used    = 0;
      sched_count = 8'd0;
      window_len  = WINDOW_RESET;
      pending_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if (cfg_we) window_len = cfg_wdata;
      if (req_valid && !req_stall) predict_request(req);
    end
    results_due <= pending_results.size();
    mismatches  <= fail_total;
  end

endmodule

@@ tb/sv/periodic_task_dispatcher_tb.sv @@
`timescale 1ns / 100ps

module periodic_task_dispatcher_tb;
  import ptd_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 2_000_000;

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  ptd_req_t   req;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  ptd_rsp_t   rsp;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int mismatches;
  int results_due;
  int cycles     = 0;
  int stall_left = 0;
  int sent       = 0;
  bit req_quiet  = 1'b0;
  bit rsp_quiet  = 1'b0;

  always #4 clk = ~clk;

  periodic_task_dispatcher i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ptd_dispatch_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short idle spans, now and then a long one
  function automatic int pick_span();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    logic hold;
    if ($urandom_range(0, 255) == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left--;
      hold = 1'b1;
    end else if (rsp_quiet || $urandom_range(0, 99) >= 30) begin
      hold = 1'b0;
    end else begin
      stall_left = pick_span() - 1;
      hold = 1'b1;
    end
    rsp_stall <= hold;
  end

  function automatic logic [7:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 8'd0;
    if (roll < 85) return 8'($urandom_range(1, 12));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'd0;
    if (roll < 70) return 8'($urandom_range(1, 6));
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(logic [1:0] act, logic [7:0] id, logic [7:0] per,
                              logic [PRI_W-1:0] pri);
    int       gap;
    ptd_req_t r;
    r.action       = act;
    r.task_id      = id;
    r.period       = per;
    r.priority_req = pri;
    gap = (req_quiet || $urandom_range(0, 99) < 55) ? 0 : pick_span();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent++;
    if (sent % 32 == 0) req_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic random_request(int tick_pct);
    int         roll;
    logic [1:0] act;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      act = ACT_TICK;
    end else begin
      roll = $urandom_range(0, 9);
      act  = (roll < 5) ? ACT_CREATE : (roll < 9) ? ACT_DELETE : ACT_UNUSED;
    end
    send_request(act, pick_id(), pick_period(), PRI_W'($urandom_range(0, 7)));
  endtask

  task automatic random_run(int n, int tick_pct);
    repeat (n) random_request(tick_pct);
  endtask

  task automatic tick_run(int n);
    repeat (n) send_request(ACT_TICK, 8'($urandom), 8'($urandom), PRI_W'($urandom));
  endtask

  // drop valid and hold until every expected result has been taken
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [7:0] len);
    drain();
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // null ids, absent delete on an empty table, unused action, empty tick
    send_request(ACT_CREATE, 8'd0, 8'd5, 3'd1);
    send_request(ACT_DELETE, 8'd0, 8'd0, 3'd0);
    send_request(ACT_DELETE, 8'd9, 8'd0, 3'd0);
    send_request(ACT_UNUSED, 8'hFF, 8'hFF, 3'd7);
    send_request(ACT_TICK, 8'd0, 8'd0, 3'd0);
    // fill the table: extreme fields, a zero period and a duplicate id
    send_request(ACT_CREATE, 8'd255, 8'd255, 3'd7);
    send_request(ACT_CREATE, 8'd1, 8'd1, 3'd0);
    send_request(ACT_CREATE, 8'd2, 8'd2, 3'd7);
    send_request(ACT_CREATE, 8'd3, 8'd0, 3'd0);
    send_request(ACT_CREATE, 8'd2, 8'd3, 3'd3);
    send_request(ACT_CREATE, 8'hAA, 8'd4, 3'd0);
    send_request(ACT_CREATE, 8'h55, 8'd1, 3'd5);
    send_request(ACT_CREATE, 8'd4, 8'd6, 3'd2);
    send_request(ACT_CREATE, 8'd5, 8'd1, 3'd0);
    tick_run(6);
    // duplicate id: only the first copy goes
    send_request(ACT_DELETE, 8'd2, 8'd0, 3'd0);
    send_request(ACT_DELETE, 8'd200, 8'd0, 3'd0);
    tick_run(2);

    // keep the counter well above 10 for the lowered-window sweep below
    write_window(8'd255);
    tick_run(4);
    random_run(30, 50);

    // window below the counter: count through 255, dispatch at 0, then wrap at 10
    write_window(8'd10);
    tick_run(256);

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ptd_pkg.sv
rtl/core/periodic_task_dispatcher.sv
tb/sv/ptd_dispatch_checker.sv
tb/sv/periodic_task_dispatcher_tb.sv
